FILE: hw/rtl/sss_pkg.sv
// Shared types, constants and the segment decode of the seven-segment text scanner.
package sss_pkg;

  localparam int NUM_DIGITS_DEF = 3;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int SEG_W    = 7;
  localparam int DSEL_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 4;
  localparam int DWELL_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // commit status codes
  localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_COMMIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 2'd1;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd500;
  localparam logic [CODE_W-1:0]  BLANK_CODE  = 4'd10;

  localparam logic [BYTE_W-1:0] CHAR_NL  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2E;

  typedef struct packed {
    logic              fire;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] text_byte;
  } step_t;

  // segments a..g, a in bit 6
  function automatic logic [SEG_W-1:0] seg_decode(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 7'h7E;
      4'd1:    seg = 7'h30;
      4'd2:    seg = 7'h6D;
      4'd3:    seg = 7'h79;
      4'd4:    seg = 7'h33;
      4'd5:    seg = 7'h5B;
      4'd6:    seg = 7'h5F;
      4'd7:    seg = 7'h70;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h7B;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: hw/rtl/sss_in_if.sv
// Input channel: valid/ready word carrying kind and text byte.
interface sss_in_if;
  logic                       valid;
  logic                       ready;
  logic [sss_pkg::KIND_W-1:0] kind;
  logic [sss_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

FILE: hw/rtl/sss_out_if.sv
// Result channel: valid/ready word carrying the display drive and commit status.
interface sss_out_if;
  logic                         valid;
  logic                         ready;
  logic [sss_pkg::SEG_W-1:0]    segments;
  logic [sss_pkg::DSEL_W-1:0]   digit_select;
  logic                         point;
  logic [sss_pkg::STATUS_W-1:0] commit_status;

  modport source (output valid, output segments, output digit_select, output point,
                  output commit_status, input ready);
  modport sink   (input valid, input segments, input digit_select, input point,
                  input commit_status, output ready);
endinterface

FILE: hw/rtl/sss_cfg_if.sv
// Configuration write channel: valid/ready word carrying register index and data.
interface sss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sss_pkg::CFG_IDX_W-1:0]  index;
  logic [sss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/sss_text.sv
// Text staging, validation and commit of the shown digit codes and points.
module sss_text #(
  parameter int NUM_DIGITS = sss_pkg::NUM_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sss_pkg::step_t               step,
  output logic [sss_pkg::CODE_W-1:0]   shown_codes_nxt [NUM_DIGITS],
  output logic                         shown_pts_nxt   [NUM_DIGITS],
  output logic [sss_pkg::STATUS_W-1:0] status_nxt
);

  localparam int FW = $clog2(NUM_DIGITS + 1);

  logic [sss_pkg::CODE_W-1:0] shown_codes_r [NUM_DIGITS];
  logic                       shown_pts_r   [NUM_DIGITS];
  logic [sss_pkg::CODE_W-1:0] stg_codes_r   [NUM_DIGITS];
  logic [sss_pkg::CODE_W-1:0] stg_codes_nxt [NUM_DIGITS];
  logic                       stg_pts_r     [NUM_DIGITS];
  logic                       stg_pts_nxt   [NUM_DIGITS];
  logic [FW-1:0]              fill_r, fill_nxt;
  logic                       reject_r, reject_nxt;

  logic is_digit, is_letter, prev_pt, full;
  logic [sss_pkg::BYTE_W-1:0] b;

  assign b         = step.text_byte;
  assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
  assign is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
                     (b == sss_pkg::CHAR_SP);
  assign full      = (fill_r == FW'(NUM_DIGITS));

  always_comb begin
    prev_pt = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (int'(fill_r) == i + 1) prev_pt = stg_pts_r[i];
    end
  end

  always_comb begin
    stg_codes_nxt   = stg_codes_r;
    stg_pts_nxt     = stg_pts_r;
    shown_codes_nxt = shown_codes_r;
    shown_pts_nxt   = shown_pts_r;
    fill_nxt        = fill_r;
    reject_nxt      = reject_r;
    status_nxt      = sss_pkg::STATUS_NONE;
    if (step.fire) begin
      case (step.kind)
        sss_pkg::KIND_BYTE: begin
          if (!reject_r) begin
            if (full) begin
              reject_nxt = 1'b1;
            end else if (b == sss_pkg::CHAR_NL) begin
              // skip newline
            end else if (is_digit || is_letter) begin
              for (int i = 0; i < NUM_DIGITS; i++) begin
                if (int'(fill_r) == i) begin
                  stg_codes_nxt[i] = is_digit ? b[3:0] : sss_pkg::BLANK_CODE;
                  stg_pts_nxt[i]   = 1'b0;
                end
              end
              fill_nxt = fill_r + FW'(1);
            end else if (b == sss_pkg::CHAR_DOT) begin
              if ((fill_r != '0) && !prev_pt) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                  if (int'(fill_r) == i + 1) stg_pts_nxt[i] = 1'b1;
                end
              end else begin
                // dot alone takes a blank position of its own
                for (int i = 0; i < NUM_DIGITS; i++) begin
                  if (int'(fill_r) == i) begin
                    stg_codes_nxt[i] = sss_pkg::BLANK_CODE;
                    stg_pts_nxt[i]   = 1'b1;
                  end
                end
                fill_nxt = fill_r + FW'(1);
              end
            end else begin
              reject_nxt = 1'b1;
            end
          end
        end
        sss_pkg::KIND_END: begin
          if (reject_r) begin
            status_nxt = sss_pkg::STATUS_REJECT;
          end else begin
            shown_codes_nxt = stg_codes_r;
            shown_pts_nxt   = stg_pts_r;
            status_nxt      = sss_pkg::STATUS_COMMIT;
          end
          for (int i = 0; i < NUM_DIGITS; i++) begin
            stg_codes_nxt[i] = sss_pkg::BLANK_CODE;
            stg_pts_nxt[i]   = 1'b0;
          end
          fill_nxt   = '0;
          reject_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        shown_codes_r[i] <= sss_pkg::BLANK_CODE;
        shown_pts_r[i]   <= 1'b0;
        stg_codes_r[i]   <= sss_pkg::BLANK_CODE;
        stg_pts_r[i]     <= 1'b0;
      end
      fill_r   <= '0;
      reject_r <= 1'b0;
    end else begin
      shown_codes_r <= shown_codes_nxt;
      shown_pts_r   <= shown_pts_nxt;
      stg_codes_r   <= stg_codes_nxt;
      stg_pts_r     <= stg_pts_nxt;
      fill_r        <= fill_nxt;
      reject_r      <= reject_nxt;
    end
  end

endmodule

FILE: hw/rtl/sss_scan.sv
// Dwell counter and digit scan position.
module sss_scan #(
  parameter int NUM_DIGITS = sss_pkg::NUM_DIGITS_DEF,
  parameter int SW         = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sss_pkg::step_t              step,
  input  logic [sss_pkg::DWELL_W-1:0] dwell_ticks,
  input  logic                        display_enable,
  output logic [SW-1:0]               scan_nxt
);

  logic [sss_pkg::DWELL_W-1:0] count_r, count_nxt, count_inc, limit;
  logic [SW-1:0]               scan_r;

  assign limit     = (dwell_ticks == '0) ? sss_pkg::DWELL_W'(1) : dwell_ticks;
  assign count_inc = count_r + sss_pkg::DWELL_W'(1);

  always_comb begin
    count_nxt = count_r;
    scan_nxt  = scan_r;
    if (step.fire && (step.kind == sss_pkg::KIND_TICK) && display_enable) begin
      count_nxt = count_inc;
      if (count_inc >= limit) begin
        // advance to the next digit, wrap after the last
        count_nxt = '0;
        scan_nxt  = (scan_r == SW'(NUM_DIGITS - 1)) ? '0 : scan_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      scan_r  <= '0;
    end else begin
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule

FILE: hw/rtl/seven_segment_text_scanner.sv
// Top level of the seven-segment text scanner: config registers, pipeline and output decode.
//
// Drives a multiplexed seven-segment display from a stream of words on in_ch.
// Each word is a tick, a text byte (value string sent last byte first) or an
// end mark that commits the staged string or reports its rejection.
// Every accepted input word yields exactly one result word on out_ch: the
// segments, digit select (one-hot, all zero while the display is disabled)
// and point of the lit digit after that word, plus the commit status.
// Each word passes an input register and then a result register, from which
// its result is offered on out_ch. One word is taken every cycle while out_ch
// drains.
// When the receiver holds out_ready low, the result register holds its word,
// the input register fills, and in_ready drops until the result is taken.
// Configuration writes on cfg_ch (dwell ticks, display enable) are always
// ready and take effect at once; write them while no words are in flight.
// Synchronous reset blanks all digits, clears staging and the scan, sets the
// dwell to 500 ticks and disables the display.
module seven_segment_text_scanner #(
  parameter int NUM_DIGITS = sss_pkg::NUM_DIGITS_DEF
) (
  input logic  clk,
  input logic  rst_n,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch,
  sss_cfg_if.sink   cfg_ch
);

  localparam int SW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [sss_pkg::DWELL_W-1:0] dwell_ticks_r;
  logic                        display_enable_r;

  logic                        in_valid_r;
  logic [sss_pkg::KIND_W-1:0]  kind_r;
  logic [sss_pkg::BYTE_W-1:0]  byte_r;
  logic                        out_valid_r;
  logic [sss_pkg::SEG_W-1:0]   seg_r, seg_nxt;
  logic [sss_pkg::DSEL_W-1:0]  dsel_r, dsel_nxt;
  logic                        point_r, point_nxt;
  logic [sss_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                        advance;
  sss_pkg::step_t              step;
  logic [sss_pkg::CODE_W-1:0]  shown_codes_nxt [NUM_DIGITS];
  logic                        shown_pts_nxt   [NUM_DIGITS];
  logic [SW-1:0]               scan_nxt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r    <= sss_pkg::DWELL_RESET;
      display_enable_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sss_pkg::REG_DWELL_TICKS:    dwell_ticks_r    <= cfg_ch.data[sss_pkg::DWELL_W-1:0];
        sss_pkg::REG_DISPLAY_ENABLE: display_enable_r <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // the result register frees when empty or taken this cycle
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  assign step.fire      = in_valid_r && advance;
  assign step.kind      = kind_r;
  assign step.text_byte = byte_r;

  sss_text #(.NUM_DIGITS(NUM_DIGITS)) u_text (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .shown_codes_nxt (shown_codes_nxt),
    .shown_pts_nxt   (shown_pts_nxt),
    .status_nxt      (status_nxt)
  );

  sss_scan #(.NUM_DIGITS(NUM_DIGITS), .SW(SW)) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .dwell_ticks    (dwell_ticks_r),
    .display_enable (display_enable_r),
    .scan_nxt       (scan_nxt)
  );

  always_comb begin
    seg_nxt   = '0;
    dsel_nxt  = '0;
    point_nxt = 1'b0;
    if (display_enable_r) begin
      seg_nxt   = sss_pkg::seg_decode(shown_codes_nxt[scan_nxt]);
      point_nxt = shown_pts_nxt[scan_nxt];
      for (int i = 0; i < sss_pkg::DSEL_W; i++) begin
        dsel_nxt[i] = (int'(scan_nxt) == i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (advance) out_valid_r <= in_valid_r;
    end
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      byte_r <= in_ch.text_byte;
    end
    if (step.fire) begin
      seg_r    <= seg_nxt;
      dsel_r   <= dsel_nxt;
      point_r  <= point_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.segments      = seg_r;
  assign out_ch.digit_select  = dsel_r;
  assign out_ch.point         = point_r;
  assign out_ch.commit_status = status_r;

endmodule
